[design/countdown_timer_pool_top_macros.svh]
// Assertion macros for the countdown timer pool.
`ifndef COUNTDOWN_TIMER_POOL_TOP_MACROS_SVH
`define COUNTDOWN_TIMER_POOL_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define CTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define CTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ctp_pkg.sv]
// Shared types and constants for the countdown timer pool.
`timescale 1ns / 1ps

package ctp_pkg;

    localparam int FUNC_W       = 2;
    localparam int TIMER_ID_W   = 4;
    localparam int TICK_W       = 16;
    localparam int TIME_W       = 63;
    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 8;

    localparam int US_PER_MS     = 1000;
    localparam int MS_PER_SECOND = 1000;

    localparam int DIV_NUM_W     = 64;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_CYCLES    = DIV_NUM_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_START = 2'd0,
        FUNC_CHECK = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

endpackage

[design/ctp_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module ctp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/countdown_timer_pool_top.sv]
// Countdown timer pool: per-id tick counts and a pool of slots that track running timers.
`timescale 1ns / 1ps
`include "countdown_timer_pool_top_macros.svh"

// One item at a time; tready is high only while the sequencer is idle. An id at or above
// NUM_TIMER_IDS is first reduced by repeated subtraction of NUM_TIMER_IDS. A start then
// writes the tick count and visits slots one by one (reading and evaluating each busy slot
// on a restart); a clear or an unused operation goes straight to the finish step. A check
// visits every slot, and for each busy slot does a slot RAM read, a load, a run of the
// shared divider (4 quotient bits a cycle over a 64-bit dividend) and a compare. A busy slot
// whose start time lies ahead of the item's time skips the divider. The finish step moves the
// result to the output register once the previous result has been taken; tick counts read
// as zero until first written, and no clearing pass is needed after reset.
module countdown_timer_pool_top #(
    parameter int NUM_SLOTS        = 8,
    parameter int NUM_TIMER_IDS    = 16,
    parameter int TICKS_PER_SECOND = 100
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ctp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // timer_id, tick_count, now_us
    input  logic [ctp_pkg::FUNC_W-1:0]       s_axis_tuser,   // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ctp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // ok, expired
);

    localparam int ID_W    = (NUM_TIMER_IDS > 1) ? $clog2(NUM_TIMER_IDS) : 1;
    localparam int SL_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DIVISOR = ctp_pkg::US_PER_MS * (ctp_pkg::MS_PER_SECOND / TICKS_PER_SECOND);
    localparam int REM_W   = $clog2(DIVISOR);
    localparam int T_W     = REM_W + 1;
    localparam int SLOT_W  = ID_W + ctp_pkg::TIME_W;
    localparam int TW      = ctp_pkg::TIME_W;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_REDUCE = 13'b0000000000010,
        ST_S_DEC  = 13'b0000000000100,
        ST_S_FIND = 13'b0000000001000,
        ST_R_SLOT = 13'b0000000010000,
        ST_R_EVAL = 13'b0000000100000,
        ST_C_SLOT = 13'b0000001000000,
        ST_C_LOAD = 13'b0000010000000,
        ST_C_DIV  = 13'b0000100000000,
        ST_C_CMP  = 13'b0001000000000,
        ST_C_ID   = 13'b0010000000000,
        ST_C_RES  = 13'b0100000000000,
        ST_FINISH = 13'b1000000000000
    } t_state;

    t_state                              r_state, n_state;
    ctp_pkg::t_func                      r_func, n_func;
    logic [ctp_pkg::TIMER_ID_W-1:0]      r_id, n_id;
    logic [ctp_pkg::TICK_W-1:0]          r_ticks, n_ticks;
    logic [TW-1:0]                       r_now, n_now;
    logic                                r_ok, n_ok;
    logic                                r_expired, n_expired;
    logic [SL_W-1:0]                     r_slot, n_slot;
    logic [ID_W-1:0]                     r_owner, n_owner;
    logic [NUM_SLOTS-1:0]                r_busy, n_busy;
    logic [NUM_TIMER_IDS-1:0]            r_cnt_vld, n_cnt_vld;
    logic                                r_cnt_hit, n_cnt_hit;
    logic [ctp_pkg::DIV_NUM_W-1:0]       r_num, n_num;
    logic [REM_W-1:0]                    r_rem, n_rem;
    logic [ctp_pkg::TICK_W-1:0]          r_quo, n_quo;
    logic [ctp_pkg::DIV_CNT_W-1:0]       r_div_cnt, n_div_cnt;
    logic                                r_out_valid, n_out_valid;
    logic                                r_out_ok, n_out_ok;
    logic                                r_out_expired, n_out_expired;

    logic                                cnt_we, cnt_re;
    logic [ID_W-1:0]                     cnt_waddr, cnt_raddr;
    logic [ctp_pkg::TICK_W-1:0]          cnt_wdata, cnt_rdata;
    logic                                slot_we, slot_re;
    logic [SLOT_W-1:0]                   slot_wdata, slot_rdata;

    logic [ID_W-1:0]                     w_id;
    logic [ctp_pkg::TICK_W-1:0]          w_cnt;
    logic [TW-1:0]                       w_start;
    logic [ID_W-1:0]                     w_owner;
    logic                                w_last;
    logic [ctp_pkg::DIV_NUM_W-1:0]       w_num_step;
    logic [REM_W-1:0]                    w_rem_step;
    logic [ctp_pkg::TICK_W-1:0]          w_quo_step;

    assign w_id    = ID_W'(r_id);
    assign w_cnt   = r_cnt_hit ? cnt_rdata : '0;
    assign w_start = slot_rdata[TW-1:0];
    assign w_owner = slot_rdata[SLOT_W-1:TW];
    assign w_last  = (r_slot == SL_W'(NUM_SLOTS - 1));

    ctp_ram #(
        .WIDTH (ctp_pkg::TICK_W),
        .DEPTH (NUM_TIMER_IDS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    ctp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (r_slot),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (r_slot),
        .o_rdata (slot_rdata)
    );

    // Shared divider: DIV_STEP_BITS restoring steps per cycle
    always_comb begin
        logic [T_W-1:0] trial;
        w_num_step = r_num;
        w_rem_step = r_rem;
        w_quo_step = r_quo;
        for (int k = 0; k < ctp_pkg::DIV_STEP_BITS; k++) begin
            trial      = {w_rem_step, w_num_step[ctp_pkg::DIV_NUM_W-1]};
            w_num_step = {w_num_step[ctp_pkg::DIV_NUM_W-2:0], 1'b0};
            if (trial >= T_W'(DIVISOR)) begin
                w_rem_step = REM_W'(trial - T_W'(DIVISOR));
                w_quo_step = {w_quo_step[ctp_pkg::TICK_W-2:0], 1'b1};
            end else begin
                w_rem_step = REM_W'(trial);
                w_quo_step = {w_quo_step[ctp_pkg::TICK_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        n_func        = r_func;
        n_id          = r_id;
        n_ticks       = r_ticks;
        n_now         = r_now;
        n_ok          = r_ok;
        n_expired     = r_expired;
        n_slot        = r_slot;
        n_owner       = r_owner;
        n_busy        = r_busy;
        n_cnt_vld     = r_cnt_vld;
        n_cnt_hit     = r_cnt_hit;
        n_num         = r_num;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_div_cnt     = r_div_cnt;
        n_out_valid   = r_out_valid;
        n_out_ok      = r_out_ok;
        n_out_expired = r_out_expired;
        cnt_we        = 1'b0;
        cnt_waddr     = w_id;
        cnt_wdata     = '0;
        cnt_re        = 1'b0;
        cnt_raddr     = w_id;
        slot_we       = 1'b0;
        slot_wdata    = {w_id, r_now};
        slot_re       = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func    = ctp_pkg::t_func'(s_axis_tuser);
                    n_id      = s_axis_tdata[3:0];
                    n_ticks   = s_axis_tdata[19:4];
                    n_now     = s_axis_tdata[82:20];
                    n_ok      = 1'b0;
                    n_expired = 1'b0;
                    n_state   = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if ({5'b0, r_id} >= 9'(NUM_TIMER_IDS)) begin
                    n_id = r_id - 4'(NUM_TIMER_IDS);
                end else begin
                    cnt_re = 1'b1;
                    n_slot = '0;
                    case (r_func)
                        ctp_pkg::FUNC_START: n_state = ST_S_DEC;
                        ctp_pkg::FUNC_CHECK: n_state = ST_C_SLOT;
                        ctp_pkg::FUNC_CLEAR: begin
                            n_busy  = '0;
                            n_state = ST_FINISH;
                        end
                        default: n_state = ST_FINISH;
                    endcase
                end
            end
            ST_S_DEC: begin
                cnt_we           = 1'b1;
                cnt_wdata        = r_ticks;
                n_cnt_vld[w_id]  = 1'b1;
                if (w_cnt != '0) begin
                    n_ok    = 1'b1;
                    n_state = ST_R_SLOT;
                end else begin
                    n_state = ST_S_FIND;
                end
            end
            ST_S_FIND: begin
                if (!r_busy[r_slot]) begin
                    slot_we        = 1'b1;
                    n_busy[r_slot] = 1'b1;
                    n_ok           = 1'b1;
                    n_state        = ST_FINISH;
                end else if (w_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_R_SLOT: begin
                if (r_busy[r_slot]) begin
                    slot_re = 1'b1;
                    n_state = ST_R_EVAL;
                end else if (w_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_R_EVAL: begin
                if (w_owner == w_id) begin
                    slot_we = 1'b1;
                end
                if (w_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = ST_R_SLOT;
                end
            end
            ST_C_SLOT: begin
                if (r_busy[r_slot]) begin
                    slot_re = 1'b1;
                    n_state = ST_C_LOAD;
                end else if (w_last) begin
                    n_state = ST_C_ID;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ST_C_LOAD: begin
                n_owner   = w_owner;
                cnt_re    = 1'b1;
                cnt_raddr = w_owner;
                n_rem     = '0;
                n_quo     = '0;
                n_div_cnt = '0;
                if (r_now < w_start) begin
                    n_state = ST_C_CMP;
                end else begin
                    n_num   = {1'b0, r_now - w_start};
                    n_state = ST_C_DIV;
                end
            end
            ST_C_DIV: begin
                n_num     = w_num_step;
                n_rem     = w_rem_step;
                n_quo     = w_quo_step;
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == ctp_pkg::DIV_CNT_W'(ctp_pkg::DIV_CYCLES - 1)) begin
                    n_state = ST_C_CMP;
                end
            end
            ST_C_CMP: begin
                if (r_quo >= w_cnt) begin
                    cnt_we             = 1'b1;
                    cnt_waddr          = r_owner;
                    n_cnt_vld[r_owner] = 1'b1;
                    n_busy[r_slot]     = 1'b0;
                end
                if (w_last) begin
                    n_state = ST_C_ID;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = ST_C_SLOT;
                end
            end
            ST_C_ID: begin
                cnt_re  = 1'b1;
                n_state = ST_C_RES;
            end
            ST_C_RES: begin
                n_expired = (w_cnt == '0);
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_ok      = r_ok;
                    n_out_expired = r_expired;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (cnt_re) begin
            n_cnt_hit = r_cnt_vld[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= '0;
            r_cnt_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_cnt_vld   <= n_cnt_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_id          <= n_id;
        r_ticks       <= n_ticks;
        r_now         <= n_now;
        r_ok          <= n_ok;
        r_expired     <= n_expired;
        r_slot        <= n_slot;
        r_owner       <= n_owner;
        r_cnt_hit     <= n_cnt_hit;
        r_num         <= n_num;
        r_rem         <= n_rem;
        r_quo         <= n_quo;
        r_div_cnt     <= n_div_cnt;
        r_out_ok      <= n_out_ok;
        r_out_expired <= n_out_expired;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_expired, r_out_ok};

    `CTP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "sequencer ready again straight after an accepted item")
    `CTP_ASSERT_NOW(a_result_from_finish, $rose(r_out_valid), $past(r_state == ST_FINISH),
        "result register loaded outside the finish step")
    `CTP_ASSERT_NEXT(a_div_ends_in_compare,
        r_state == ST_C_DIV && r_div_cnt == ctp_pkg::DIV_CNT_W'(ctp_pkg::DIV_CYCLES - 1),
        r_state == ST_C_CMP, "divider did not hand over to the compare step")
    `CTP_ASSERT_NEXT(a_free_slot_skipped, r_state == ST_C_SLOT && !r_busy[r_slot],
        r_state != ST_C_LOAD, "free slot loaded during a check")

endmodule
